>>> rtl/tbp_pkg.sv
// Package with shared widths, types and codes for the two-button press unit.
`timescale 1ns / 1ps

package tbp_pkg;

    localparam int TIME_BITS      = 32;
    localparam int THRESH_BITS    = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    localparam logic [THRESH_BITS-1:0] LONG_PRESS_RESET = THRESH_BITS'(450);
    localparam logic [THRESH_BITS-1:0] MIN_PRESS_RESET  = THRESH_BITS'(30);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_LONG_PRESS = 1'b0,
        CFG_MIN_PRESS  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        EV_NONE         = 3'd0,
        EV_FIRST_LONG   = 3'd1,
        EV_FIRST_SHORT  = 3'd2,
        EV_SECOND_LONG  = 3'd3,
        EV_SECOND_SHORT = 3'd4
    } event_code_t;

    typedef enum logic [1:0] {
        BEV_NONE  = 2'd0,
        BEV_LONG  = 2'd1,
        BEV_SHORT = 2'd2
    } button_ev_t;

    typedef struct packed {
        logic                 prev_level;
        logic [TIME_BITS-1:0] press_time;
        logic                 long_done;
    } button_state_t;

    typedef struct packed {
        logic [THRESH_BITS-1:0] long_press_ms;
        logic [THRESH_BITS-1:0] min_press_ms;
    } thresholds_t;

endpackage

>>> rtl/tbp_if.sv
// Valid/ready channel interfaces for poll samples and press events.
`timescale 1ns / 1ps

interface tbp_sample_if;
    import tbp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 select_pressed;
    logic                 back_pressed;
    logic [TIME_BITS-1:0] now_ms;

    modport source (output valid, output select_pressed, output back_pressed,
                    output now_ms, input ready);
    modport sink   (input valid, input select_pressed, input back_pressed,
                    input now_ms, output ready);
endinterface

interface tbp_event_if;
    import tbp_pkg::*;

    logic        valid;
    logic        ready;
    event_code_t event_code;

    modport source (output valid, output event_code, input ready);
    modport sink   (input valid, input event_code, output ready);
endinterface

>>> rtl/tbp_button_eval.sv
// Press evaluation for one button: next button state and the event it reports.
`timescale 1ns / 1ps

module tbp_button_eval (
    input  tbp_pkg::button_state_t          state,
    input  logic                            level,
    input  logic [tbp_pkg::TIME_BITS-1:0]   now_ms,
    input  tbp_pkg::thresholds_t            thresholds,
    output tbp_pkg::button_state_t          state_next,
    output tbp_pkg::button_ev_t             button_ev
);
    import tbp_pkg::*;

    logic [TIME_BITS-1:0] held;
    logic                 long_met;
    logic                 min_met;

    // The difference wraps naturally at the timestamp width.
    assign held     = now_ms - state.press_time;
    assign long_met = held >= TIME_BITS'(thresholds.long_press_ms);
    assign min_met  = held >= TIME_BITS'(thresholds.min_press_ms);

    always_comb
    begin
        state_next            = state;
        state_next.prev_level = level;
        button_ev             = BEV_NONE;
        unique case ({level, state.prev_level})
            2'b10:
            begin
                state_next.press_time = now_ms;
                state_next.long_done  = 1'b0;
            end
            2'b11:
            begin
                if (!state.long_done && long_met)
                begin
                    button_ev            = BEV_LONG;
                    state_next.long_done = 1'b1;
                end
            end
            2'b01:
            begin
                if (!state.long_done && min_met)
                begin
                    button_ev = BEV_SHORT;
                end
            end
            default:
            begin
                button_ev = BEV_NONE;
            end
        endcase
    end

endmodule

>>> rtl/two_button_short_long_press_unit.sv
// Top level of the two-button short/long press unit.
//
//   channel   direction  handshake        payload
//   sample    in         valid / ready    select_pressed, back_pressed, now_ms
//   result    out        valid / ready    event_code
//   cfg       in         cfg_write        cfg_index, cfg_data
//
// Every accepted sample gives exactly one event code, registered in the cycle after it is accepted.
// A new sample is taken each cycle while the result register is empty or is
// being drained in the same cycle, so the sustained rate is one per cycle.
// Reset restores the default thresholds and clears both button states.
// A stalled result holds in the output register and blocks new samples.
`timescale 1ns / 1ps

module two_button_short_long_press_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    tbp_sample_if.sink                          sample,
    tbp_event_if.source                         result,
    input  logic                                cfg_write,
    input  logic [tbp_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [tbp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
    import tbp_pkg::*;

    thresholds_t   thresholds_reg;
    button_state_t first_reg;
    button_state_t second_reg;
    button_state_t first_next;
    button_state_t second_next;
    button_ev_t    first_ev;
    button_ev_t    second_ev;
    event_code_t   event_code_reg;
    event_code_t   event_code_next;
    logic          valid_reg;
    logic          accept;

    assign sample.ready = !valid_reg || result.ready;
    assign accept       = sample.valid && sample.ready;

    tbp_button_eval u_first (
        .state      (first_reg),
        .level      (sample.select_pressed),
        .now_ms     (sample.now_ms),
        .thresholds (thresholds_reg),
        .state_next (first_next),
        .button_ev  (first_ev)
    );

    tbp_button_eval u_second (
        .state      (second_reg),
        .level      (sample.back_pressed),
        .now_ms     (sample.now_ms),
        .thresholds (thresholds_reg),
        .state_next (second_next),
        .button_ev  (second_ev)
    );

    // The first button wins; the second one is only looked at when the first is quiet.
    always_comb
    begin
        unique case (first_ev)
            BEV_LONG:  event_code_next = EV_FIRST_LONG;
            BEV_SHORT: event_code_next = EV_FIRST_SHORT;
            default:
            begin
                unique case (second_ev)
                    BEV_LONG:  event_code_next = EV_SECOND_LONG;
                    BEV_SHORT: event_code_next = EV_SECOND_SHORT;
                    default:   event_code_next = EV_NONE;
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresholds_reg.long_press_ms <= LONG_PRESS_RESET;
            thresholds_reg.min_press_ms  <= MIN_PRESS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_LONG_PRESS: thresholds_reg.long_press_ms <= THRESH_BITS'(cfg_data);
                CFG_MIN_PRESS:  thresholds_reg.min_press_ms  <= THRESH_BITS'(cfg_data);
                default:        thresholds_reg <= thresholds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (accept)
        begin
            first_reg <= first_next;
            if (first_ev == BEV_NONE)
            begin
                second_reg <= second_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_code_reg <= event_code_next;
        end
    end

    assign result.valid      = valid_reg;
    assign result.event_code = event_code_reg;

endmodule

>>> bench/two_button_short_long_press_unit_tb.sv
// Self-checking bench for the two-button press unit: random poll traffic, stalls, threshold sets.
`timescale 1ns / 1ps

module two_button_short_long_press_unit_tb;
    import tbp_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int LONG_HOLD_AT = 60;
    localparam int LONG_HOLD_CYCLES = 300;

    typedef struct packed {
        logic                 sel;
        logic                 back;
        logic [TIME_BITS-1:0] now_ms;
    } poll_sample_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    tbp_sample_if smp_if ();
    tbp_event_if  evt_if ();

    two_button_short_long_press_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (smp_if),
        .result    (evt_if),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    poll_sample_t         poll_queue [$];
    event_code_t          expected_events [$];
    event_code_t          want_code;
    int                   error_count = 0;
    int                   items_queued = 0;

    // Predictor state: thresholds and per-button tracking.
    logic [THRESH_BITS-1:0] thr_long;
    logic [THRESH_BITS-1:0] thr_min;
    button_state_t          btn_st [2];
    logic [TIME_BITS-1:0]   gen_now;

    // Driver burst / gap bookkeeping.
    int burst_left;
    int gap_left;

    // Receiver bookkeeping.
    int rx_count = 0;
    int rx_cycle = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;
    int watchdog_cycles;

    function automatic button_ev_t judge_button(input int idx, input logic level,
                                                input logic [TIME_BITS-1:0] now);
        button_ev_t           ev;
        logic [TIME_BITS-1:0] held;
        ev = BEV_NONE;
        held = now - btn_st[idx].press_time;
        if (level && !btn_st[idx].prev_level)
        begin
            btn_st[idx].press_time = now;
            btn_st[idx].long_done = 1'b0;
        end
        else if (level && btn_st[idx].prev_level)
        begin
            if (!btn_st[idx].long_done && held >= TIME_BITS'(thr_long))
            begin
                ev = BEV_LONG;
                btn_st[idx].long_done = 1'b1;
            end
        end
        else if (!level && btn_st[idx].prev_level)
        begin
            if (!btn_st[idx].long_done && held >= TIME_BITS'(thr_min))
                ev = BEV_SHORT;
        end
        btn_st[idx].prev_level = level;
        return ev;
    endfunction

    // The first button wins; the second is left untouched when it reports.
    function automatic event_code_t predict_event(input poll_sample_t s);
        button_ev_t ev;
        ev = judge_button(0, s.sel, s.now_ms);
        if (ev == BEV_LONG)
            return EV_FIRST_LONG;
        if (ev == BEV_SHORT)
            return EV_FIRST_SHORT;
        ev = judge_button(1, s.back, s.now_ms);
        if (ev == BEV_LONG)
            return EV_SECOND_LONG;
        if (ev == BEV_SHORT)
            return EV_SECOND_SHORT;
        return EV_NONE;
    endfunction

    function automatic int unsigned pick_duration();
        int          c;
        int unsigned d;
        c = $urandom_range(0, 5);
        if (c < 2)
            d = 32'(thr_min);
        else if (c < 4)
            d = 32'(thr_long);
        else if (c == 4)
            d = $urandom_range(0, 8);
        else
            d = $urandom_range(0, int'(thr_long) + int'(thr_min) + 1);
        if (c < 4 && d > 0 && $urandom_range(0, 1) == 1)
            d = d - 1;
        return d;
    endfunction

    task automatic push_poll(input logic sel, input logic back, input logic [TIME_BITS-1:0] now);
        poll_sample_t s;
        s.sel = sel;
        s.back = back;
        s.now_ms = now;
        poll_queue.push_back(s);
        items_queued++;
    endtask

    // Press sessions near the thresholds, with some raw noise mixed in.
    task automatic gen_sessions(input int count);
        int          target;
        int          mode;
        int          k;
        int          j;
        int unsigned dur;
        int unsigned tail;
        logic        hold_sel;
        logic        hold_back;
        target = items_queued + count;
        while (items_queued < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                push_poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
            end
            else
            begin
                mode = $urandom_range(0, 3);
                hold_sel = (mode != 1);
                hold_back = (mode != 0);
                dur = pick_duration();
                push_poll(hold_sel, hold_back, gen_now);
                k = $urandom_range(0, 3);
                for (j = 1; j <= k; j++)
                    push_poll(hold_sel, hold_back, gen_now + (dur * j) / (k + 1));
                tail = 0;
                if ($urandom_range(0, 1) == 1)
                begin
                    push_poll(hold_sel, hold_back, gen_now + dur);
                    tail = $urandom_range(0, 3);
                end
                gen_now = gen_now + dur + tail;
                if (mode == 3)
                begin
                    // The first button lets go first; the second follows later.
                    push_poll(1'b0, 1'b1, gen_now);
                    gen_now = gen_now + $urandom_range(0, dur);
                end
                push_poll(1'b0, 1'b0, gen_now);
            end
            gen_now = gen_now + $urandom_range(1, 40);
            if ($urandom_range(0, 15) == 0)
                gen_now = gen_now + $urandom();
        end
    endtask

    task automatic write_cfg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_LONG_PRESS)
            thr_long = val;
        else
            thr_min = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (poll_queue.size() != 0 || expected_events.size() != 0);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (watchdog_cycles = 0; watchdog_cycles < CYCLE_LIMIT; watchdog_cycles++)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    // Sender: bursts of transfers separated by random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_if.valid <= 1'b0;
            smp_if.select_pressed <= 1'b0;
            smp_if.back_pressed <= 1'b0;
            smp_if.now_ms <= '0;
            burst_left = $urandom_range(1, 20);
            gap_left = 0;
        end
        else
        begin
            if (smp_if.valid && smp_if.ready)
            begin
                expected_events.push_back(predict_event(poll_queue[0]));
                void'(poll_queue.pop_front());
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 6);
                    burst_left = $urandom_range(1, 20);
                end
            end
            if (smp_if.valid && !smp_if.ready)
            begin
                // Offer stays up until the transfer happens.
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                smp_if.valid <= 1'b0;
            end
            else if (poll_queue.size() > 0)
            begin
                smp_if.valid <= 1'b1;
                smp_if.select_pressed <= poll_queue[0].sel;
                smp_if.back_pressed <= poll_queue[0].back;
                smp_if.now_ms <= poll_queue[0].now_ms;
            end
            else
            begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each transfer and stalls on its own pattern.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_if.ready <= 1'b0;
        end
        else
        begin
            rx_cycle++;
            if (evt_if.valid && evt_if.ready)
            begin
                rx_count++;
                if (expected_events.size() == 0)
                begin
                    $display("%0t ERROR: event_code expected nothing actual %0d",
                             $time, evt_if.event_code);
                    error_count++;
                end
                else
                begin
                    want_code = expected_events.pop_front();
                    if (evt_if.event_code !== want_code)
                    begin
                        $display("%0t ERROR: event_code expected %0d actual %0d",
                                 $time, want_code, evt_if.event_code);
                        error_count++;
                    end
                end
            end
            // One long hold-off lets the output register fill and back up the input.
            if (!long_hold_done && rx_count == LONG_HOLD_AT)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                evt_if.ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 128) % 4)
                    0: evt_if.ready <= 1'b1;
                    1: evt_if.ready <= ($urandom_range(0, 3) != 0);
                    2: evt_if.ready <= 1'($urandom_range(0, 1));
                    default: evt_if.ready <= 1'(16'b1011_0111_0010_1101 >> (rx_cycle % 16));
                endcase
            end
        end
    end

    initial
    begin
        logic [TIME_BITS-1:0] t0;
        smp_if.valid = 1'b0;
        smp_if.select_pressed = 1'b0;
        smp_if.back_pressed = 1'b0;
        smp_if.now_ms = '0;
        evt_if.ready = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_LONG_PRESS;
        cfg_data = '0;
        rst_n = 1'b0;
        thr_long = LONG_PRESS_RESET;
        thr_min = MIN_PRESS_RESET;
        btn_st[0] = '0;
        btn_st[1] = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Reset thresholds, directed cases; the base time makes the sequence cross the wrap.
        @(negedge clk);
        t0 = 32'hFFFF_FE00;
        push_poll(1'b0, 1'b0, 32'h0000_0000);
        push_poll(1'b0, 1'b0, 32'hFFFF_FFFF);
        push_poll(1'b1, 1'b0, t0);
        push_poll(1'b1, 1'b0, t0 + 100);
        push_poll(1'b1, 1'b0, t0 + 449);
        push_poll(1'b1, 1'b0, t0 + 450);
        push_poll(1'b1, 1'b0, t0 + 600);
        push_poll(1'b0, 1'b0, t0 + 700);
        push_poll(1'b1, 1'b0, t0 + 710);
        push_poll(1'b0, 1'b0, t0 + 739);
        push_poll(1'b1, 1'b0, t0 + 740);
        push_poll(1'b0, 1'b0, t0 + 770);
        push_poll(1'b0, 1'b1, t0 + 780);
        push_poll(1'b0, 1'b0, t0 + 810);
        push_poll(1'b0, 1'b1, t0 + 820);
        push_poll(1'b0, 1'b1, t0 + 1270);
        push_poll(1'b0, 1'b0, t0 + 1300);
        push_poll(1'b1, 1'b1, t0 + 1400);
        push_poll(1'b1, 1'b1, t0 + 1850);
        push_poll(1'b1, 1'b1, t0 + 1851);
        push_poll(1'b0, 1'b0, t0 + 1900);
        push_poll(1'b1, 1'b1, t0 + 2000);
        push_poll(1'b0, 1'b0, t0 + 2040);
        push_poll(1'b0, 1'b0, t0 + 2041);
        gen_now = t0 + 2100;
        gen_sessions(80);
        wait_drained();

        // Zero thresholds: any held sample is long, any plain release is short.
        write_cfg(CFG_LONG_PRESS, 16'h0000);
        write_cfg(CFG_MIN_PRESS, 16'h0000);
        @(negedge clk);
        push_poll(1'b1, 1'b0, gen_now);
        push_poll(1'b1, 1'b0, gen_now);
        push_poll(1'b0, 1'b0, gen_now);
        push_poll(1'b0, 1'b1, gen_now);
        push_poll(1'b0, 1'b0, gen_now);
        gen_sessions(60);
        wait_drained();

        write_cfg(CFG_LONG_PRESS, 16'hFFFF);
        write_cfg(CFG_MIN_PRESS, 16'hFFFF);
        @(negedge clk);
        gen_sessions(60);
        wait_drained();

        write_cfg(CFG_LONG_PRESS, 16'($urandom_range(20, 200)));
        write_cfg(CFG_MIN_PRESS, 16'($urandom_range(0, 20)));
        @(negedge clk);
        gen_sessions(80);
        wait_drained();

        // Minimum above the long threshold, so shorts need a release before long fires.
        write_cfg(CFG_LONG_PRESS, 16'd10);
        write_cfg(CFG_MIN_PRESS, 16'd40);
        @(negedge clk);
        gen_sessions(60);
        wait_drained();

        write_cfg(CFG_LONG_PRESS, 16'($urandom_range(0, 65535)));
        write_cfg(CFG_MIN_PRESS, 16'($urandom_range(0, 65535)));
        @(negedge clk);
        gen_sessions(60);
        wait_drained();

        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_events.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
rtl/tbp_pkg.sv
rtl/tbp_if.sv
rtl/tbp_button_eval.sv
rtl/two_button_short_long_press_unit.sv
bench/two_button_short_long_press_unit_tb.sv
